FILE: sv/multilevel_priority_queue_core_macros.svh
// ----------------------------------------------------------------------------
// multilevel priority queue assertion macros
// concurrent assertion helpers shared by the controller and the datapath
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_PRIORITY_QUEUE_CORE_MACROS_SVH
`define MULTILEVEL_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define MLPQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MLPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MLPQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define MLPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: sv/mlpq_pkg.sv
// ----------------------------------------------------------------------------
// mlpq_pkg
// sizes, codes, types and ring helpers of the multilevel priority queue
// ----------------------------------------------------------------------------
package mlpq_pkg;

   localparam int LEVELS      = 8;
   localparam int LEVEL_DEPTH = 16;
   localparam int SLOT_COUNT  = LEVELS * LEVEL_DEPTH;

   // transaction field widths
   localparam int FUNC_W  = 2;
   localparam int PRIO_W  = 4;
   localparam int TID_W   = 8;
   localparam int OLVL_W  = 4;
   localparam int TOTAL_W = 9;

   // internal widths
   localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int IDX_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);
   localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   typedef logic [LVL_W-1:0]   lvl_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [FILL_W-1:0]  fill_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [TOTAL_W-1:0] total_type;
   typedef logic [TID_W-1:0]   tid_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD      = 2'd0,
      FUNC_POP_HEAD = 2'd1,
      FUNC_POP_TAIL = 2'd2,
      FUNC_NOP      = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_NONE  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_EXEC,
      CTRL_WAIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic load_out;
   } ctrl_cmd_type;

   // (a + b) mod LEVEL_DEPTH for a, b below LEVEL_DEPTH
   function automatic idx_type ring_wrap(input idx_type a, input idx_type b);
      logic [IDX_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (IDX_W+1)'(LEVEL_DEPTH)) begin
         sum = sum - (IDX_W+1)'(LEVEL_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

FILE: sv/mlpq_req_if.sv
// ----------------------------------------------------------------------------
// mlpq_req_if
// request channel: operation, level and thread identifier
// ----------------------------------------------------------------------------
interface mlpq_req_if import mlpq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [PRIO_W-1:0] priority_req;
   logic [TID_W-1:0]  thread_id;

   modport source (output valid, func, priority_req, thread_id, input ready);
   modport sink   (input valid, func, priority_req, thread_id, output ready);
endinterface

FILE: sv/mlpq_rsp_if.sv
// ----------------------------------------------------------------------------
// mlpq_rsp_if
// response channel: status, removed thread, level, empty flag and count
// ----------------------------------------------------------------------------
interface mlpq_rsp_if import mlpq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [TID_W-1:0]   out_thread;
   logic [OLVL_W-1:0]  out_level;
   logic               all_empty;
   logic [TOTAL_W-1:0] total;

   modport source (output valid, status, out_thread, out_level, all_empty, total,
                   input ready);
   modport sink   (input valid, status, out_thread, out_level, all_empty, total,
                   output ready);
endinterface

FILE: sv/mlpq_ctrl.sv
// ----------------------------------------------------------------------------
// mlpq_ctrl
// sequencer: capture, execute against the queue state, hand off the response
// ----------------------------------------------------------------------------
`include "multilevel_priority_queue_core_macros.svh"

module mlpq_ctrl import mlpq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTRL_IDLE: begin
            if (req_valid) state_in = CTRL_EXEC;
         end
         CTRL_EXEC: begin
            state_in = CTRL_WAIT;
         end
         CTRL_WAIT: begin
            if (out_free) state_in = req_valid ? CTRL_EXEC : CTRL_IDLE;
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.load_out = 1'b0;
      cmd.execute  = 1'b0;
      case (state_ff)
         CTRL_IDLE: begin
            req_ready = 1'b1;
         end
         CTRL_EXEC: begin
            cmd.execute = 1'b1;
         end
         CTRL_WAIT: begin
            req_ready    = out_free;
            cmd.load_out = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd.capture = req_valid && req_ready;
   end

   always_comb begin
      if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTRL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `MLPQ_ASSERT_NEXT(a_capture_exec, clock, reset, cmd.capture, state_ff == CTRL_EXEC, "capture not followed by execute")
   `MLPQ_ASSERT_NEXT(a_exec_wait, clock, reset, state_ff == CTRL_EXEC, state_ff == CTRL_WAIT, "execute not followed by wait")
   `MLPQ_ASSERT_NEXT(a_load_valid, clock, reset, cmd.load_out, rsp_valid_ff, "loaded response not valid")

endmodule

FILE: sv/mlpq_dp.sv
// ----------------------------------------------------------------------------
// mlpq_dp
// per-level ring pointers, slot memory, counters and response register
// ----------------------------------------------------------------------------
`include "multilevel_priority_queue_core_macros.svh"

module mlpq_dp import mlpq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [PRIO_W-1:0]  req_priority_req,
   input  logic [TID_W-1:0]   req_thread_id,
   output logic [1:0]         rsp_status,
   output logic [TID_W-1:0]   rsp_out_thread,
   output logic [OLVL_W-1:0]  rsp_out_level,
   output logic               rsp_all_empty,
   output logic [TOTAL_W-1:0] rsp_total
);

   // captured request
   func_type            func_ff;
   logic [PRIO_W-1:0]   prio_ff;
   tid_type             tid_ff;

   // queue state
   idx_type             head_ff [LEVELS];
   idx_type             head_in [LEVELS];
   fill_type            fill_ff [LEVELS];
   fill_type            fill_in [LEVELS];
   total_type           total_ff, total_in;
   tid_type             slots_mem [SLOT_COUNT];
   tid_type             rdata_ff;

   // pending result between execute and hand-off
   status_type          res_status_ff, res_status_in;
   logic [OLVL_W-1:0]   res_level_ff, res_level_in;
   logic                res_take_ff, res_take_in;

   // response register
   logic [1:0]          rsp_status_ff;
   tid_type             rsp_thread_ff;
   logic [OLVL_W-1:0]   rsp_level_ff;
   logic                rsp_empty_ff;
   total_type           rsp_total_ff;

   logic     found_lo, found_hi;
   lvl_type  lvl_lo, lvl_hi, sel_lvl;
   fill_type sel_fill;
   idx_type  sel_head, offset, pos;
   addr_type addr;
   logic     prio_ok, full, do_add, do_pop;

   // lowest and highest non-empty levels
   always_comb begin
      found_lo = 1'b0;
      lvl_lo   = '0;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (fill_ff[l] != '0) begin
            found_lo = 1'b1;
            lvl_lo   = LVL_W'(l);
         end
      end
   end

   always_comb begin
      found_hi = 1'b0;
      lvl_hi   = '0;
      for (int l = 0; l < LEVELS; l++) begin
         if (fill_ff[l] != '0) begin
            found_hi = 1'b1;
            lvl_hi   = LVL_W'(l);
         end
      end
   end

   assign prio_ok = {1'b0, prio_ff} < (PRIO_W+1)'(LEVELS);

   always_comb begin
      case (func_ff)
         FUNC_ADD:      sel_lvl = prio_ff[LVL_W-1:0];
         FUNC_POP_HEAD: sel_lvl = lvl_lo;
         FUNC_POP_TAIL: sel_lvl = lvl_hi;
         default:       sel_lvl = '0;
      endcase
   end

   assign sel_fill = fill_ff[sel_lvl];
   assign sel_head = head_ff[sel_lvl];
   assign full     = sel_fill == FILL_W'(LEVEL_DEPTH);

   always_comb begin
      case (func_ff)
         FUNC_ADD:      offset = sel_fill[IDX_W-1:0];
         FUNC_POP_TAIL: offset = IDX_W'(sel_fill - FILL_W'(1));
         default:       offset = '0;
      endcase
   end

   assign pos  = ring_wrap(sel_head, offset);
   assign addr = ADDR_W'(ADDR_W'(sel_lvl) * ADDR_W'(LEVEL_DEPTH)) + ADDR_W'(pos);

   assign do_add = (func_ff == FUNC_ADD) && prio_ok && !full;
   assign do_pop = ((func_ff == FUNC_POP_HEAD) && found_lo) ||
                   ((func_ff == FUNC_POP_TAIL) && found_hi);

   // state update and pending result
   always_comb begin
      head_in       = head_ff;
      fill_in       = fill_ff;
      total_in      = total_ff;
      res_status_in = STATUS_DONE;
      res_level_in  = '0;
      res_take_in   = 1'b0;
      case (func_ff)
         FUNC_ADD: begin
            res_level_in = OLVL_W'(prio_ff);
            if (!prio_ok) res_status_in = STATUS_RANGE;
            else if (full) res_status_in = STATUS_FULL;
         end
         FUNC_POP_HEAD, FUNC_POP_TAIL: begin
            if (do_pop) begin
               res_level_in = OLVL_W'(sel_lvl);
               res_take_in  = 1'b1;
            end else begin
               res_status_in = STATUS_NONE;
            end
         end
         default: begin
            res_status_in = STATUS_DONE;
         end
      endcase
      if (do_add) begin
         fill_in[sel_lvl] = sel_fill + FILL_W'(1);
         total_in         = total_ff + TOTAL_W'(1);
      end
      if (do_pop) begin
         fill_in[sel_lvl] = sel_fill - FILL_W'(1);
         total_in         = total_ff - TOTAL_W'(1);
         if (func_ff == FUNC_POP_HEAD) head_in[sel_lvl] = ring_wrap(sel_head, IDX_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l] <= '0;
            fill_ff[l] <= '0;
         end
         total_ff <= '0;
      end else if (cmd.execute) begin
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
      end
   end

   // slot memory, one access per execute
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         if (do_add) slots_mem[addr] <= tid_ff;
         rdata_ff <= slots_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= func_type'(req_func);
         prio_ff <= req_priority_req;
         tid_ff  <= req_thread_id;
      end
      if (cmd.execute) begin
         res_status_ff <= res_status_in;
         res_level_ff  <= res_level_in;
         res_take_ff   <= res_take_in;
      end
      if (cmd.load_out) begin
         rsp_status_ff <= res_status_ff;
         rsp_thread_ff <= res_take_ff ? rdata_ff : '0;
         rsp_level_ff  <= res_level_ff;
         rsp_empty_ff  <= total_ff == '0;
         rsp_total_ff  <= total_ff;
      end
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_out_thread = rsp_thread_ff;
   assign rsp_out_level  = rsp_level_ff;
   assign rsp_all_empty  = rsp_empty_ff;
   assign rsp_total      = rsp_total_ff;

   `MLPQ_ASSERT_NEXT(a_add_count, clock, reset, cmd.execute && do_add, total_ff == $past(total_ff) + TOTAL_W'(1), "add did not bump total")
   `MLPQ_ASSERT_NEXT(a_idle_count, clock, reset, cmd.execute && !do_add && !do_pop, $stable(total_ff), "total moved without add or removal")
   `MLPQ_ASSERT_NOW(a_total_bound, clock, reset, 1'b1, total_ff <= TOTAL_W'(SLOT_COUNT), "total above capacity")

endmodule

FILE: sv/multilevel_priority_queue_core.sv
// a request is captured, executed (pointer update plus one slot memory access)
//   and loaded into the response register, which raises response valid; a new
//   request is accepted while the previous response is loaded, not in execute
// in the wait state a stalled response keeps req ready low until it is taken
// reset: synchronous, active high; all levels empty, total zero, no response
//   valid; slot memory contents are not cleared
// ----------------------------------------------------------------------------
// multilevel_priority_queue_core
// one fifo of thread identifiers per priority level with head and tail removal
// ----------------------------------------------------------------------------
module multilevel_priority_queue_core import mlpq_pkg::*; (
   input logic        clock,
   input logic        reset,
   mlpq_req_if.sink   req_chan,
   mlpq_rsp_if.source rsp_chan
);

   // command bundle from the sequencer to the datapath
   ctrl_cmd_type cmd;

   // sequencer: accepts a transaction in idle or while handing off the
   // previous response, then runs the execute step and the response hand-off
   mlpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // datapath: ring pointers per level, shared slot memory with registered
   // read, running total and the response register
   mlpq_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_func         (req_chan.func),
      .req_priority_req (req_chan.priority_req),
      .req_thread_id    (req_chan.thread_id),
      .rsp_status       (rsp_chan.status),
      .rsp_out_thread   (rsp_chan.out_thread),
      .rsp_out_level    (rsp_chan.out_level),
      .rsp_all_empty    (rsp_chan.all_empty),
      .rsp_total        (rsp_chan.total)
   );

endmodule
